/* src/spk_pkg.sv */
// ----------------------------------------------------------------------------
// spk_pkg: shared types, codes and microprogram of the path length checker
// Holds field widths, register codes, the control word layout and the
// read-only microprogram that the sequencer steps through.
// ----------------------------------------------------------------------------
package spk_pkg;

   localparam int MAX_VERTICES_DEF = 32;

   // field widths
   localparam int VTX_W        = 5;
   localparam int COUNT_W      = 6;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 6;
   localparam int REQ_TDATA_W  = 16;
   localparam int RSP_TDATA_W  = 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_COUNT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_VERTEX  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_VERTEX = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PATH_LENGTH   = 2'd3;

   localparam logic [COUNT_W-1:0] VERTEX_COUNT_RST = 6'd32;

   // microprogram steps
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] ST_LOAD    = 4'd0;
   localparam logic [STEP_W-1:0] ST_INIT    = 4'd1;
   localparam logic [STEP_W-1:0] ST_CHECK   = 4'd2;
   localparam logic [STEP_W-1:0] ST_SCAN    = 4'd3;
   localparam logic [STEP_W-1:0] ST_TEST    = 4'd4;
   localparam logic [STEP_W-1:0] ST_ARRIVE  = 4'd5;
   localparam logic [STEP_W-1:0] ST_POP     = 4'd6;
   localparam logic [STEP_W-1:0] ST_RESTORE = 4'd7;
   localparam logic [STEP_W-1:0] ST_ANSWER  = 4'd8;

   // datapath operations
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_NONE    = 3'd0;
   localparam logic [OP_W-1:0] OP_START   = 3'd1;
   localparam logic [OP_W-1:0] OP_FOUND   = 3'd2;
   localparam logic [OP_W-1:0] OP_NEXT    = 3'd3;
   localparam logic [OP_W-1:0] OP_PUSH    = 3'd4;
   localparam logic [OP_W-1:0] OP_RETREAT = 3'd5;
   localparam logic [OP_W-1:0] OP_RESTORE = 3'd6;
   localparam logic [OP_W-1:0] OP_FINISH  = 3'd7;

   // branch conditions
   localparam int COND_W = 4;
   localparam logic [COND_W-1:0] C_ALWAYS    = 4'd0;
   localparam logic [COND_W-1:0] C_LAST      = 4'd1;
   localparam logic [COND_W-1:0] C_RANGE_BAD = 4'd2;
   localparam logic [COND_W-1:0] C_ZERO_HIT  = 4'd3;
   localparam logic [COND_W-1:0] C_EXHAUST   = 4'd4;
   localparam logic [COND_W-1:0] C_CAND_OK   = 4'd5;
   localparam logic [COND_W-1:0] C_AT_GOAL   = 4'd6;
   localparam logic [COND_W-1:0] C_DEPTH0    = 4'd7;
   localparam logic [COND_W-1:0] C_RSP_FREE  = 4'd8;

   typedef struct packed {
      logic [COUNT_W-1:0] vertex_count;
      logic [VTX_W-1:0]   start_vertex;
      logic [VTX_W-1:0]   target_vertex;
      logic [VTX_W-1:0]   path_length;
   } cfg_type;

   typedef struct packed {
      logic              ready;
      logic [COND_W-1:0] cond;
      logic [OP_W-1:0]   op_t;
      logic [OP_W-1:0]   op_f;
      logic [STEP_W-1:0] tgt_t;
      logic [STEP_W-1:0] tgt_f;
   } uword_type;

   typedef struct packed {
      logic            ready;
      logic [OP_W-1:0] op;
   } ctl_type;

   typedef struct packed {
      logic last_xfer;
      logic range_bad;
      logic zero_hit;
      logic exhaust;
      logic cand_ok;
      logic at_goal;
      logic depth0;
      logic rsp_free;
   } flags_type;

   // One word per step: branch on cond, run op_t/op_f, go to tgt_t/tgt_f.
   function automatic uword_type ucode_rom(input logic [STEP_W-1:0] step);
      uword_type w;
      case (step)
         ST_LOAD:    w = '{1'b1, C_LAST,      OP_NONE,   OP_NONE,    ST_INIT,   ST_LOAD};
         ST_INIT:    w = '{1'b0, C_RANGE_BAD, OP_NONE,   OP_START,   ST_ANSWER, ST_CHECK};
         ST_CHECK:   w = '{1'b0, C_ZERO_HIT,  OP_FOUND,  OP_NONE,    ST_ANSWER, ST_SCAN};
         ST_SCAN:    w = '{1'b0, C_EXHAUST,   OP_NONE,   OP_NONE,    ST_POP,    ST_TEST};
         ST_TEST:    w = '{1'b0, C_CAND_OK,   OP_PUSH,   OP_NEXT,    ST_ARRIVE, ST_SCAN};
         ST_ARRIVE:  w = '{1'b0, C_AT_GOAL,   OP_FOUND,  OP_NONE,    ST_ANSWER, ST_SCAN};
         ST_POP:     w = '{1'b0, C_DEPTH0,    OP_NONE,   OP_RETREAT, ST_ANSWER, ST_RESTORE};
         ST_RESTORE: w = '{1'b0, C_ALWAYS,    OP_RESTORE, OP_NONE,   ST_SCAN,   ST_SCAN};
         ST_ANSWER:  w = '{1'b0, C_RSP_FREE,  OP_FINISH, OP_NONE,    ST_LOAD,   ST_ANSWER};
         default:    w = '{1'b0, C_ALWAYS,    OP_NONE,   OP_NONE,    ST_LOAD,   ST_LOAD};
      endcase
      return w;
   endfunction

endpackage

/* src/spk_seq.sv */
// ----------------------------------------------------------------------------
// spk_seq: microprogram sequencer
// Step counter, control word lookup and two-way conditional branch.
// ----------------------------------------------------------------------------
module spk_seq (
   input  logic                clock,
   input  logic                reset,
   input  spk_pkg::flags_type  flags,
   output spk_pkg::ctl_type    ctl
);
   import spk_pkg::*;

   logic [STEP_W-1:0] upc_ff;
   logic [STEP_W-1:0] upc_in;
   uword_type         word;
   logic              taken;

   assign word = ucode_rom(upc_ff);

   always_comb begin
      case (word.cond)
         C_ALWAYS:    taken = 1'b1;
         C_LAST:      taken = flags.last_xfer;
         C_RANGE_BAD: taken = flags.range_bad;
         C_ZERO_HIT:  taken = flags.zero_hit;
         C_EXHAUST:   taken = flags.exhaust;
         C_CAND_OK:   taken = flags.cand_ok;
         C_AT_GOAL:   taken = flags.at_goal;
         C_DEPTH0:    taken = flags.depth0;
         C_RSP_FREE:  taken = flags.rsp_free;
         default:     taken = 1'b1;
      endcase
   end

   assign upc_in    = taken ? word.tgt_t : word.tgt_f;
   assign ctl.op    = taken ? word.op_t : word.op_f;
   assign ctl.ready = word.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= ST_LOAD;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

/* src/spk_dp.sv */
// ----------------------------------------------------------------------------
// spk_dp: search datapath
// Adjacency memory with row valid bits, path stack memory, current vertex,
// neighbor cursor, depth and visited mask; raises branch flags.
// ----------------------------------------------------------------------------
module spk_dp #(
   parameter int MAX_VERTICES = spk_pkg::MAX_VERTICES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  spk_pkg::cfg_type          cfg,
   input  logic [spk_pkg::VTX_W-1:0] arc_from,
   input  logic [spk_pkg::VTX_W-1:0] arc_to,
   input  logic                      arc_last,
   input  logic                      arc_xfer,
   input  logic                      rsp_free,
   input  spk_pkg::ctl_type          ctl,
   output spk_pkg::flags_type        flags,
   output logic                      found
);
   import spk_pkg::*;

   localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CW = VW + 1;
   localparam int LW = (CW > COUNT_W) ? CW : COUNT_W;

   logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
   logic [VW-1:0]           stk_v_mem [MAX_VERTICES];
   logic [CW-1:0]           stk_c_mem [MAX_VERTICES];

   logic [MAX_VERTICES-1:0] row_valid_ff;
   logic [MAX_VERTICES-1:0] adj_q_ff;
   logic                    adjv_q_ff;
   logic [VW-1:0]           stk_v_q_ff;
   logic [CW-1:0]           stk_c_q_ff;

   logic [VW-1:0]           v_ff, v_in;
   logic [CW-1:0]           cur_ff, cur_in;
   logic [VW-1:0]           d_ff, d_in;
   logic [MAX_VERTICES-1:0] visited_ff, visited_in;
   logic                    found_ff, found_in;

   logic [LW-1:0] n_l, vc_l, max_l, s_l, t_l, k_l, from_l, to_l, cur_l, d_l, v_l;
   logic [VW-1:0] from_idx, to_idx, cur_idx, s_idx, d_dec;
   logic [MAX_VERTICES-1:0] row_eff, cur_bit, v_bit, s_bit, to_bit;
   logic          arc_wr;

   assign vc_l   = LW'(cfg.vertex_count);
   assign max_l  = LW'(MAX_VERTICES);
   assign n_l    = (vc_l > max_l) ? max_l : vc_l;
   assign s_l    = LW'(cfg.start_vertex);
   assign t_l    = LW'(cfg.target_vertex);
   assign k_l    = LW'(cfg.path_length);
   assign from_l = LW'(arc_from);
   assign to_l   = LW'(arc_to);
   assign cur_l  = LW'(cur_ff);
   assign d_l    = LW'(d_ff);
   assign v_l    = LW'(v_ff);

   assign from_idx = from_l[VW-1:0];
   assign to_idx   = to_l[VW-1:0];
   assign s_idx    = s_l[VW-1:0];
   assign cur_idx  = cur_ff[VW-1:0];
   assign d_dec    = d_ff - VW'(1);

   assign cur_bit = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << cur_idx;
   assign v_bit   = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << v_ff;
   assign s_bit   = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << s_idx;
   assign to_bit  = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << to_idx;

   assign arc_wr  = arc_xfer && (from_l < n_l) && (to_l < n_l);
   assign row_eff = adjv_q_ff ? adj_q_ff : '0;

   // branch flags
   assign flags.last_xfer = arc_xfer && arc_last;
   assign flags.range_bad = (s_l >= n_l) || (t_l >= n_l);
   assign flags.zero_hit  = (s_l == t_l) && (k_l == '0);
   assign flags.exhaust   = (d_l >= k_l) || (cur_l >= n_l);
   assign flags.cand_ok   = row_eff[cur_idx] && !visited_ff[cur_idx]
                            && !((cur_l == t_l) && ((d_l + LW'(1)) != k_l));
   assign flags.at_goal   = (v_l == t_l) && (d_l == k_l);
   assign flags.depth0    = (d_ff == '0);
   assign flags.rsp_free  = rsp_free;

   assign found = found_ff;

   always_comb begin
      v_in       = v_ff;
      cur_in     = cur_ff;
      d_in       = d_ff;
      visited_in = visited_ff;
      found_in   = found_ff;
      case (ctl.op)
         OP_START: begin
            v_in       = s_idx;
            cur_in     = '0;
            d_in       = '0;
            visited_in = s_bit;
            found_in   = 1'b0;
         end
         OP_FOUND: begin
            found_in = 1'b1;
         end
         OP_NEXT: begin
            cur_in = cur_ff + CW'(1);
         end
         OP_PUSH: begin
            v_in       = cur_idx;
            cur_in     = '0;
            d_in       = d_ff + VW'(1);
            visited_in = visited_ff | cur_bit;
         end
         OP_RETREAT: begin
            visited_in = visited_ff & ~v_bit;
            d_in       = d_dec;
         end
         OP_RESTORE: begin
            v_in   = stk_v_q_ff;
            cur_in = stk_c_q_ff;
         end
         OP_FINISH: begin
            visited_in = '0;
            found_in   = 1'b0;
            d_in       = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff       <= '0;
         visited_ff <= '0;
         found_ff   <= 1'b0;
      end else begin
         d_ff       <= d_in;
         visited_ff <= visited_in;
         found_ff   <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff   <= v_in;
      cur_ff <= cur_in;
   end

   // row valid bits: an invalid row reads as empty
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (ctl.op == OP_FINISH) begin
         row_valid_ff <= '0;
      end else if (arc_wr) begin
         row_valid_ff[from_idx] <= 1'b1;
      end
   end

   // adjacency memory: bit write on a live row, whole row on a cleared one
   always_ff @(posedge clock) begin
      if (arc_wr) begin
         if (row_valid_ff[from_idx]) begin
            adj_mem[from_idx][to_idx] <= 1'b1;
         end else begin
            adj_mem[from_idx] <= to_bit;
         end
      end
      adj_q_ff  <= adj_mem[v_in];
      adjv_q_ff <= row_valid_ff[v_in];
   end

   // path stack: parent vertex and resume cursor per depth
   always_ff @(posedge clock) begin
      if (ctl.op == OP_PUSH) begin
         stk_v_mem[d_ff] <= v_ff;
         stk_c_mem[d_ff] <= cur_ff + CW'(1);
      end
      stk_v_q_ff <= stk_v_mem[d_dec];
      stk_c_q_ff <= stk_c_mem[d_dec];
   end

endmodule

/* src/simple_path_length_k_check.sv */
// Arcs: one transfer per clock while loading; each accepted in-range arc sets one bit.
// Search after the last arc: set up, answer at once if an endpoint is out of range
// or a zero-length path fits, else test each neighbor in turn, step down the path
// to a candidate, step back up off the stack, and give up back at the start vertex.
// Answer leaves through an output register while the next graph loads; the next
// waits for it to drain. Reset (synchronous, active high) empties graph and result.
// ----------------------------------------------------------------------------
// simple_path_length_k_check: exact length simple path detector
// Collects directed arcs into an adjacency matrix, then runs a microcoded
// depth-first search for a simple path of the configured length.
// ----------------------------------------------------------------------------
module simple_path_length_k_check #(
   parameter int MAX_VERTICES = spk_pkg::MAX_VERTICES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // input arcs
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [spk_pkg::REQ_TDATA_W-1:0] req_tdata,  // arc_from[4:0], arc_to[9:5]
   input  logic                           req_tlast,  // last_arc
   // results
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [spk_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // path_found[0]
   // register writes
   input  logic                           csr_wen,
   input  logic [spk_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [spk_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import spk_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   ctl_type   ctl;
   flags_type flags;
   logic      found;
   logic      arc_xfer;
   logic      rsp_free;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_found_ff;

   // configuration registers: take the write, masked to register width
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_VERTEX_COUNT:  cfg_in.vertex_count  = csr_wdata;
            CSR_START_VERTEX:  cfg_in.start_vertex  = csr_wdata[VTX_W-1:0];
            CSR_TARGET_VERTEX: cfg_in.target_vertex = csr_wdata[VTX_W-1:0];
            CSR_PATH_LENGTH:   cfg_in.path_length   = csr_wdata[VTX_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.vertex_count  <= VERTEX_COUNT_RST;
         cfg_ff.start_vertex  <= '0;
         cfg_ff.target_vertex <= '0;
         cfg_ff.path_length   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // arcs are taken only while the microprogram sits in its load step
   assign req_tready = ctl.ready;
   assign arc_xfer   = req_tvalid && req_tready;

   // the answer step may finish once the output register is free or draining
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   spk_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctl   (ctl)
   );

   spk_dp #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .arc_from (req_tdata[VTX_W-1:0]),
      .arc_to   (req_tdata[2*VTX_W-1:VTX_W]),
      .arc_last (req_tlast),
      .arc_xfer (arc_xfer),
      .rsp_free (rsp_free),
      .ctl      (ctl),
      .flags    (flags),
      .found    (found)
   );

   // output register: load on finish, drop on transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tvalid && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctl.op == OP_FINISH) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.op == OP_FINISH) begin
         rsp_found_ff <= found;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-1){1'b0}}, rsp_found_ff};

`ifndef SYNTH
   // a result appears only from a finish step
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(ctl.op == OP_FINISH))
      else $error("result raised without a finish step");

   // a finish never overwrites an undelivered result
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (ctl.op == OP_FINISH) |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten before transfer");

   // after a finish the block is back to loading arcs
   a_back_to_load: assert property (@(posedge clock) disable iff (reset)
      (ctl.op == OP_FINISH) |=> req_tready)
      else $error("not loading after finish");
`endif

endmodule
